>>> rtl/lbsf_pkg.sv
// Shared types, constants and neighbor table for the largest blob size finder.
package lbsf_pkg;

    localparam int SIZE_W = 13;
    localparam int CFG_W  = 7;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_POP,
        ST_POP_WAIT,
        ST_NB_SEL,
        ST_NB_CHK,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        STEP_NEG,
        STEP_ZERO,
        STEP_POS
    } t_step;

    // Row step of neighbor k, center skipped.
    function automatic t_step nb_row_step(input logic [2:0] k);
        t_step s;
        case (k)
            3'd0, 3'd1, 3'd2: s = STEP_NEG;
            3'd3, 3'd4:       s = STEP_ZERO;
            default:          s = STEP_POS;
        endcase
        return s;
    endfunction

    // Column step of neighbor k, center skipped.
    function automatic t_step nb_col_step(input logic [2:0] k);
        t_step s;
        case (k)
            3'd0, 3'd3, 3'd5: s = STEP_NEG;
            3'd1, 3'd6:       s = STEP_ZERO;
            default:          s = STEP_POS;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/lbsf_ram.sv
// Single write port, single registered read port RAM.
module lbsf_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/largest_blob_size_finder_core.sv
// Largest 8-connected blob size finder: pixel loader, scan and BFS flood-fill sequencer.
// Loading accepts one pixel per cycle. After the last pixel the sequencer scans every loaded
//   cell, flood-fills from each set cell and checks its neighbors, then presents the result;
//   the reads of the cell map and the queue are registered.
// Throughput: one image at a time; busy stays high from the last pixel to the result.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset (synchronous, active low) clears control state; memories hold no reset.
module largest_blob_size_finder_core #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic                       i_pixel,
    input  logic                       i_last_pixel,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lbsf_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [lbsf_pkg::CFG_W-1:0] i_cfg_data,
    output logic                       o_valid,
    output logic [lbsf_pkg::SIZE_W-1:0] o_largest_size
);
    import lbsf_pkg::*;

    localparam int SLOTS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int QW    = AW + RW + CW;
    localparam int NW    = AW + 1;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [CW:0]      w_eff;
    logic [RW:0]      h_eff;
    logic [NW-1:0]    cap;

    logic [NW-1:0] r_load_pos, n_load_pos;
    logic [NW-1:0] r_loaded, n_loaded;
    logic [NW-1:0] r_scan_idx, n_scan_idx;
    logic [RW-1:0] r_scan_row, n_scan_row;
    logic [CW-1:0] r_scan_col, n_scan_col;
    logic [NW-1:0] r_head, n_head;
    logic [NW-1:0] r_tail, n_tail;
    logic [NW-1:0] r_count, n_count;
    logic [NW-1:0] r_best, n_best;
    logic [2:0]    r_k, n_k;
    logic [QW-1:0] r_cur, n_cur;
    logic [QW-1:0] r_nb, n_nb;

    logic          cm_we, cm_wdata, cm_rdata;
    logic [AW-1:0] cm_waddr, cm_raddr;
    logic          q_we;
    logic [AW-1:0] q_waddr, q_raddr;
    logic [QW-1:0] q_wdata, q_rdata;

    logic          accept;
    logic [NW-1:0] load_next;
    logic [NW-1:0] scan_next;
    logic          scan_last;

    // neighbor evaluation
    logic [AW-1:0] cur_addr;
    logic [RW-1:0] cur_row;
    logic [CW-1:0] cur_col;
    t_step         rs, cs;
    logic          nb_ok;
    logic [RW-1:0] nb_row;
    logic [CW-1:0] nb_col;
    logic [NW-1:0] nb_base, nb_addr;

    assign accept      = i_start && (r_state == ST_LOAD);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W'(64);
            r_cfg_h <= CFG_W'(64);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_GRID_WIDTH) begin
                r_cfg_w <= i_cfg_data;
            end else if (i_cfg_index == REG_GRID_HEIGHT) begin
                r_cfg_h <= i_cfg_data;
            end
        end
    end

    // Clamp the sizes to 1..MAX.
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = (CW+1)'(1);
        end else if ({4'd0, r_cfg_w} > 11'(MAX_WIDTH)) begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (CW+1)'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = (RW+1)'(1);
        end else if ({4'd0, r_cfg_h} > 11'(MAX_HEIGHT)) begin
            h_eff = (RW+1)'(MAX_HEIGHT);
        end else begin
            h_eff = (RW+1)'(r_cfg_h);
        end
        cap = NW'(w_eff) * NW'(h_eff);
    end

    assign load_next = (r_load_pos < cap) ? r_load_pos + NW'(1) : r_load_pos;
    assign scan_next = r_scan_idx + NW'(1);
    assign scan_last = (scan_next == r_loaded);

    assign cur_addr = r_cur[QW-1 -: AW];
    assign cur_row  = r_cur[RW+CW-1 -: RW];
    assign cur_col  = r_cur[CW-1:0];

    always_comb begin
        rs      = nb_row_step(r_k);
        cs      = nb_col_step(r_k);
        nb_ok   = 1'b1;
        nb_row  = cur_row;
        nb_col  = cur_col;
        nb_base = NW'(cur_addr);
        case (rs)
            STEP_NEG: begin
                nb_ok   = (cur_row != '0);
                nb_row  = cur_row - RW'(1);
                nb_base = NW'(cur_addr) - NW'(w_eff);
            end
            STEP_POS: begin
                nb_ok   = ({1'b0, cur_row} + (RW+1)'(1)) < h_eff;
                nb_row  = cur_row + RW'(1);
                nb_base = NW'(cur_addr) + NW'(w_eff);
            end
            default: ;
        endcase
        nb_addr = nb_base;
        case (cs)
            STEP_NEG: begin
                nb_ok   = nb_ok && (cur_col != '0);
                nb_col  = cur_col - CW'(1);
                nb_addr = nb_base - NW'(1);
            end
            STEP_POS: begin
                nb_ok   = nb_ok && (({1'b0, cur_col} + (CW+1)'(1)) < w_eff);
                nb_col  = cur_col + CW'(1);
                nb_addr = nb_base + NW'(1);
            end
            default: ;
        endcase
        nb_ok = nb_ok && (nb_addr < r_loaded);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (accept && i_last_pixel) begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                n_state = (r_loaded == '0) ? ST_DONE : ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (cm_rdata) begin
                    n_state = ST_POP;
                end else begin
                    n_state = scan_last ? ST_DONE : ST_SCAN_RD;
                end
            end
            ST_POP: begin
                if (r_head == r_tail) begin
                    n_state = scan_last ? ST_DONE : ST_SCAN_RD;
                end else begin
                    n_state = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT: n_state = ST_NB_SEL;
            ST_NB_SEL: begin
                if (nb_ok) begin
                    n_state = ST_NB_CHK;
                end else if (r_k == 3'd7) begin
                    n_state = ST_POP;
                end
            end
            ST_NB_CHK: n_state = (r_k == 3'd7) ? ST_POP : ST_NB_SEL;
            ST_DONE:   n_state = ST_LOAD;
            default:   n_state = ST_LOAD;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_load_pos = r_load_pos;
        n_loaded   = r_loaded;
        n_scan_idx = r_scan_idx;
        n_scan_row = r_scan_row;
        n_scan_col = r_scan_col;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_best     = r_best;
        n_k        = r_k;
        n_cur      = r_cur;
        n_nb       = r_nb;
        cm_we      = 1'b0;
        cm_waddr   = r_load_pos[AW-1:0];
        cm_wdata   = 1'b0;
        cm_raddr   = r_scan_idx[AW-1:0];
        q_we       = 1'b0;
        q_waddr    = r_tail[AW-1:0];
        q_wdata    = r_nb;
        q_raddr    = r_head[AW-1:0];
        o_valid    = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    cm_we      = (r_load_pos < cap);
                    cm_wdata   = i_pixel;
                    n_load_pos = load_next;
                    if (i_last_pixel) begin
                        n_loaded   = (load_next < cap) ? load_next : cap;
                        n_scan_idx = '0;
                        n_scan_row = '0;
                        n_scan_col = '0;
                        n_best     = '0;
                    end
                end
            end
            ST_SCAN_CHK: begin
                if (cm_rdata) begin
                    // Seed a new blob.
                    cm_we    = 1'b1;
                    cm_waddr = r_scan_idx[AW-1:0];
                    q_we     = 1'b1;
                    q_waddr  = '0;
                    q_wdata  = {r_scan_idx[AW-1:0], r_scan_row, r_scan_col};
                    n_head   = '0;
                    n_tail   = NW'(1);
                    n_count  = NW'(1);
                end else begin
                    n_scan_idx = scan_next;
                    if (NW'(r_scan_col) + NW'(1) == NW'(w_eff)) begin
                        n_scan_col = '0;
                        n_scan_row = r_scan_row + RW'(1);
                    end else begin
                        n_scan_col = r_scan_col + CW'(1);
                    end
                end
            end
            ST_POP: begin
                if (r_head == r_tail) begin
                    if (r_count > r_best) begin
                        n_best = r_count;
                    end
                    n_scan_idx = scan_next;
                    if (NW'(r_scan_col) + NW'(1) == NW'(w_eff)) begin
                        n_scan_col = '0;
                        n_scan_row = r_scan_row + RW'(1);
                    end else begin
                        n_scan_col = r_scan_col + CW'(1);
                    end
                end else begin
                    n_head = r_head + NW'(1);
                end
            end
            ST_POP_WAIT: begin
                n_cur = q_rdata;
                n_k   = '0;
            end
            ST_NB_SEL: begin
                cm_raddr = nb_addr[AW-1:0];
                n_nb     = {nb_addr[AW-1:0], nb_row, nb_col};
                if (!nb_ok) begin
                    n_k = r_k + 3'd1;
                end
            end
            ST_NB_CHK: begin
                if (cm_rdata) begin
                    cm_we    = 1'b1;
                    cm_waddr = r_nb[QW-1 -: AW];
                    q_we     = 1'b1;
                    n_tail   = r_tail + NW'(1);
                    n_count  = r_count + NW'(1);
                end
                n_k = r_k + 3'd1;
            end
            ST_DONE: begin
                o_valid    = 1'b1;
                n_load_pos = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_pos <= '0;
            r_loaded   <= '0;
            r_scan_idx <= '0;
            r_scan_row <= '0;
            r_scan_col <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_best     <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_load_pos <= n_load_pos;
            r_loaded   <= n_loaded;
            r_scan_idx <= n_scan_idx;
            r_scan_row <= n_scan_row;
            r_scan_col <= n_scan_col;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_best     <= n_best;
            r_k        <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_nb  <= n_nb;
    end

    assign o_busy         = (r_state != ST_LOAD);
    assign o_largest_size = SIZE_W'(r_best);

    lbsf_ram #(.DEPTH(SLOTS), .AW(AW), .DW(1)) u_cell_map (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (cm_waddr),
        .i_wdata (cm_wdata),
        .i_raddr (cm_raddr),
        .o_rdata (cm_rdata)
    );

    lbsf_ram #(.DEPTH(SLOTS), .AW(AW), .DW(QW)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );
endmodule
